>>> hw/rtl/mas_pkg.sv
package mas_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_RUN    = 2'd2;

  localparam logic [1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS = 2'd1;
  localparam logic [1:0] CFG_OP_MODE  = 2'd2;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_SUB     = 2'd1;
  localparam logic [1:0] MODE_MUL     = 2'd2;
  localparam logic [1:0] MODE_MUL_ALT = 2'd3;

  localparam logic [3:0] NUM_ROWS_RST = 4'd8;
  localparam logic [3:0] NUM_COLS_RST = 4'd8;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_RUN
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_DRAIN
  } back_state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] result;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [3:0] num_rows;
    logic [3:0] num_cols;
    logic [1:0] op_mode;
  } cfg_t;

  typedef struct packed {
    cmd_e               kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/matrix_add_sub_mul.sv
// Integer matrix engine computing A+B, A-B or A times B on matrices of up to
// MAX_DIM by MAX_DIM signed elements.
// Input items arrive on the in channel (valid, stall, payload). An item either
// writes one element of A or B at its row and column, or starts a run. A run
// delivers the result matrix on the out channel in row-major order, one
// transfer per element, with last set on the final element.
// The configuration port sets row count, column count and operation; the user
// writes it only while no run is in progress; the block does not enforce it.
// Items pass through a two-entry command queue, so the input side keeps
// taking items while a run is being carried out, until the queue is full.
// While it issues a result element, the execution unit does one
// multiply-accumulate per cycle; its memory read, multiply and accumulate
// are registered stages.
// A stalled result waits in the output register and holds the execution unit.
// Reset restores the default configuration (8 by 8, add) and empties the
// queue; the element memories keep no defined contents until written.
module matrix_add_sub_mul #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  mas_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output mas_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [3:0]    cfg_data_i
);
  import mas_pkg::*;

  cfg_t      cfg_q;
  q_status_t q_stat;
  cmd_t      push_data, pop_data;
  logic      q_push, q_pop;
  int unsigned rows_lim, cols_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_rows <= NUM_ROWS_RST;
      cfg_q.num_cols <= NUM_COLS_RST;
      cfg_q.op_mode  <= MODE_ADD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_ROWS: cfg_q.num_rows <= cfg_data_i;
        CFG_NUM_COLS: cfg_q.num_cols <= cfg_data_i;
        CFG_OP_MODE:  cfg_q.op_mode  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  mas_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .push_data_o(push_data)
  );

  mas_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(push_data),
    .pop_i      (q_pop),
    .pop_data_o (pop_data),
    .q_stat_o   (q_stat)
  );

  mas_back #(
    .MAX_DIM  (MAX_DIM),
    .ELEM_BITS(ELEM_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  assign rows_lim = (int'(cfg_q.num_rows) > MAX_DIM) ? MAX_DIM : int'(cfg_q.num_rows);
  assign cols_lim = (int'(cfg_q.num_cols) > MAX_DIM) ? MAX_DIM : int'(cfg_q.num_cols);

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(out_data_o.out_row) < rows_lim)
    else $error("result row outside the configured matrix");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.out_col == 3'(cols_lim - 1))
    else $error("last flag on a column other than the final one");

endmodule

>>> hw/rtl/mas_front.sv
module mas_front #(
  parameter int MAX_DIM = 8
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mas_pkg::in_t      in_data_i,
  input  mas_pkg::cfg_t     cfg_i,
  input  mas_pkg::q_status_t q_stat_i,
  output logic              push_o,
  output mas_pkg::cmd_t     push_data_o
);
  import mas_pkg::*;

  logic keep;
  cmd_e kind;

  always_comb begin
    keep = 1'b0;
    kind = CMD_RUN;
    unique case (in_data_i.func)
      FUNC_LOAD_A: begin
        kind = CMD_LOAD_A;
        keep = (int'(in_data_i.row) < MAX_DIM) && (int'(in_data_i.col) < MAX_DIM);
      end
      FUNC_LOAD_B: begin
        kind = CMD_LOAD_B;
        keep = (int'(in_data_i.row) < MAX_DIM) && (int'(in_data_i.col) < MAX_DIM);
      end
      FUNC_RUN: begin
        kind = CMD_RUN;
        keep = (cfg_i.num_rows != 4'd0) && (cfg_i.num_cols != 4'd0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full && keep;

  assign push_data_o.kind  = kind;
  assign push_data_o.row   = in_data_i.row;
  assign push_data_o.col   = in_data_i.col;
  assign push_data_o.value = in_data_i.value;

endmodule

>>> hw/rtl/mas_queue.sv
module mas_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mas_pkg::cmd_t      push_data_i,
  input  logic               pop_i,
  output mas_pkg::cmd_t      pop_data_o,
  output mas_pkg::q_status_t q_stat_o
);
  import mas_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entry_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign q_stat_o.full  = (count_q == CW'(QUEUE_DEPTH));
  assign q_stat_o.empty = (count_q == '0);
  assign do_push        = push_i && !q_stat_o.full;
  assign do_pop         = pop_i && !q_stat_o.empty;
  assign pop_data_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hw/rtl/mas_back.sv
module mas_back #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mas_pkg::cfg_t      cfg_i,
  input  mas_pkg::q_status_t q_stat_i,
  input  mas_pkg::cmd_t      pop_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mas_pkg::out_t      out_data_o
);
  import mas_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int MW    = 2 * ELEM_BITS;
  localparam int PW    = (2 * ELEM_BITS > 32) ? 2 * ELEM_BITS : 32;

  back_state_e state_q, state_d;
  op_e         op;

  logic signed [ELEM_BITS-1:0] mem_a [DEPTH];
  logic signed [ELEM_BITS-1:0] mem_b [DEPTH];
  logic signed [ELEM_BITS-1:0] rd_a_q, rd_b_q;
  logic signed [ELEM_BITS-1:0] wr_elem;
  logic [AW-1:0]               wr_addr, addr_a, addr_b;

  logic [IW-1:0] i_q, j_q, k_q;
  logic [IW-1:0] a_col, b_row;
  logic [DW-1:0] rows_eff, cols_eff;
  logic          i_last, j_last, k_last;

  logic pop, we_a, we_b, start, issue, emit, slot_free;

  logic s1_vld_q, s1_last_q, s2_vld_q, s2_last_q, done_q;
  logic signed [31:0]          term, term_q, acc_q;
  logic signed [2*ELEM_BITS-1:0] prod_full;
  logic signed [PW-1:0]        prod_ext;

  logic out_valid_q;
  out_t out_data_q;

  always_comb begin
    unique case (cfg_i.op_mode) inside
      MODE_MUL, MODE_MUL_ALT: op = OP_MUL;
      MODE_SUB:               op = OP_SUB;
      default:                op = OP_ADD;
    endcase
  end

  assign rows_eff = (int'(cfg_i.num_rows) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_i.num_rows);
  assign cols_eff = (int'(cfg_i.num_cols) > MAX_DIM) ? DW'(MAX_DIM) : DW'(cfg_i.num_cols);

  assign i_last = (DW'(i_q) == rows_eff - DW'(1));
  assign j_last = (DW'(j_q) == cols_eff - DW'(1));
  assign k_last = (op == OP_MUL) ? (DW'(k_q) == cols_eff - DW'(1)) : 1'b1;

  assign a_col  = (op == OP_MUL) ? k_q : j_q;
  assign b_row  = (op == OP_MUL) ? k_q : i_q;
  assign addr_a = AW'(i_q) * AW'(MAX_DIM) + AW'(a_col);
  assign addr_b = AW'(b_row) * AW'(MAX_DIM) + AW'(j_q);

  assign wr_addr = AW'(pop_data_i.row) * AW'(MAX_DIM) + AW'(pop_data_i.col);
  assign wr_elem = ELEM_BITS'(pop_data_i.value);

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    pop     = 1'b0;
    we_a    = 1'b0;
    we_b    = 1'b0;
    start   = 1'b0;
    issue   = 1'b0;
    emit    = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          pop = 1'b1;
          unique case (pop_data_i.kind)
            CMD_LOAD_A: we_a = 1'b1;
            CMD_LOAD_B: we_b = 1'b1;
            CMD_RUN: begin
              start   = 1'b1;
              state_d = BK_ISSUE;
            end
            default: ;
          endcase
        end
      end
      BK_ISSUE: begin
        issue = 1'b1;
        if (k_last) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (done_q && slot_free) begin
          emit    = 1'b1;
          state_d = (i_last && j_last) ? BK_IDLE : BK_ISSUE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (start) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      if (issue) begin
        k_q <= k_last ? '0 : k_q + IW'(1);
      end
      if (emit) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + IW'(1);
        end else begin
          j_q <= j_q + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_elem;
    end
    if (we_b) begin
      mem_b[wr_addr] <= wr_elem;
    end
    if (issue) begin
      rd_a_q <= mem_a[addr_a];
      rd_b_q <= mem_b[addr_b];
    end
  end

  assign prod_full = MW'(rd_a_q) * MW'(rd_b_q);
  assign prod_ext  = PW'(prod_full);

  always_comb begin
    unique case (op)
      OP_MUL:  term = prod_ext[31:0];
      OP_SUB:  term = 32'(rd_a_q) - 32'(rd_b_q);
      default: term = 32'(rd_a_q) + 32'(rd_b_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      term_q <= term;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      done_q    <= 1'b0;
      acc_q     <= '0;
    end else begin
      s1_vld_q  <= issue;
      s1_last_q <= issue && k_last;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;
      if (emit) begin
        acc_q  <= '0;
        done_q <= 1'b0;
      end else if (s2_vld_q) begin
        acc_q  <= acc_q + term_q;
        done_q <= s2_last_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.out_row <= 3'(i_q);
      out_data_q.out_col <= 3'(j_q);
      out_data_q.result  <= acc_q;
      out_data_q.last    <= i_last && j_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> verif/mas_result_checker.sv
module mas_result_checker #(
  parameter int MAX_DIM = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  mas_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  mas_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [3:0]    cfg_data_i,
  output int unsigned   pending_o,
  output int unsigned   err_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mas_pkg::*;

  logic signed [15:0] a_elems [MAX_DIM*MAX_DIM];
  logic signed [15:0] b_elems [MAX_DIM*MAX_DIM];
  logic [3:0]         rows_q;
  logic [3:0]         cols_q;
  logic [1:0]         mode_q;
  out_t               expected_elems [$];
  int unsigned        mismatches;

  function automatic int unsigned dim_in_use(logic [3:0] d);
    if (d > MAX_DIM) return MAX_DIM;
    return d;
  endfunction

  function automatic void predict_matrix();
    int unsigned        rows;
    int unsigned        cols;
    int unsigned        i;
    int unsigned        j;
    int unsigned        k;
    logic signed [31:0] acc;
    out_t               elem;
    rows = dim_in_use(rows_q);
    cols = dim_in_use(cols_q);
    for (i = 0; i < rows; i++) begin
      for (j = 0; j < cols; j++) begin
        if (mode_q == MODE_MUL || mode_q == MODE_MUL_ALT) begin
          acc = '0;
          for (k = 0; k < cols; k++) begin
            acc = acc + a_elems[i*MAX_DIM+k] * b_elems[k*MAX_DIM+j];
          end
        end else if (mode_q == MODE_SUB) begin
          acc = a_elems[i*MAX_DIM+j] - b_elems[i*MAX_DIM+j];
        end else begin
          acc = a_elems[i*MAX_DIM+j] + b_elems[i*MAX_DIM+j];
        end
        elem.out_row = 3'(i);
        elem.out_col = 3'(j);
        elem.result  = acc;
        elem.last    = (i == rows - 1) && (j == cols - 1);
        expected_elems.push_back(elem);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int   slot;
    if (!rst_ni) begin
      rows_q = NUM_ROWS_RST;
      cols_q = NUM_COLS_RST;
      mode_q = MODE_ADD;
      expected_elems.delete();
      mismatches = 0;
      pending_o   <= 0;
      err_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_ROWS: rows_q = cfg_data_i;
          CFG_NUM_COLS: cols_q = cfg_data_i;
          CFG_OP_MODE:  mode_q = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_elems.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result transfer: row %0d col %0d value %0d last %0b",
                     out_data_i.out_row, out_data_i.out_col, out_data_i.result,
                     out_data_i.last);
          end
        end else begin
          want = expected_elems.pop_front();
          if (out_data_i.out_row !== want.out_row || out_data_i.out_col !== want.out_col ||
              out_data_i.result !== want.result || out_data_i.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result mismatch: expected row %0d col %0d value %0d last %0b",
                       want.out_row, want.out_col, want.result, want.last);
              $display("                 got      row %0d col %0d value %0d last %0b",
                       out_data_i.out_row, out_data_i.out_col, out_data_i.result,
                       out_data_i.last);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        slot = int'(in_data_i.row) * MAX_DIM + int'(in_data_i.col);
        case (in_data_i.func)
          FUNC_LOAD_A: a_elems[slot] = in_data_i.value;
          FUNC_LOAD_B: b_elems[slot] = in_data_i.value;
          FUNC_RUN:    predict_matrix();
          default: ;
        endcase
      end
      pending_o   <= expected_elems.size();
      err_count_o <= mismatches;
    end
  end

endmodule

>>> verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mas_pkg::*;

  localparam logic [1:0] FUNC_NONE      = 2'd3;
  localparam int         DIM            = 8;
  localparam int         STALL_PCT      = 29;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         SETTLE_CYCLES  = 32;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         RANDOM_ITEMS   = 75;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  in_t        in_data_i   = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_NUM_ROWS;
  logic [3:0] cfg_data_i  = 4'd0;

  int unsigned pending;
  int unsigned mismatch_cnt;
  int unsigned result_cnt   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned item_cnt     = 0;
  int unsigned run_cnt      = 0;
  int unsigned cfg_cnt      = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  logic        hold_req     = 1'b0;
  logic        calm         = 1'b0;

  logic [3:0]  cur_rows = NUM_ROWS_RST;
  logic [3:0]  cur_cols = NUM_COLS_RST;
  logic [1:0]  cur_mode = MODE_ADD;
  bit          a_set [DIM*DIM];
  bit          b_set [DIM*DIM];

  matrix_add_sub_mul DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  mas_result_checker #(.MAX_DIM(DIM)) u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i  (in_stall_o),
    .in_data_i,
    .out_valid_i (out_valid_o),
    .out_stall_i,
    .out_data_i  (out_data_o),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .pending_o   (pending),
    .err_count_o (mismatch_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < STALL_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) result_cnt <= result_cnt + 1;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending);
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic logic signed [15:0] element_value();
    case ($urandom_range(31))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2:       return 16'sh0000;
      3:       return -16'sh0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer(input logic [1:0] func, input logic [2:0] row, input logic [2:0] col,
                       input logic signed [15:0] value);
    in_t item;
    item.func  = func;
    item.row   = row;
    item.col   = col;
    item.value = value;
    if (!calm && $urandom_range(99) < STALL_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < STALL_PCT);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (func == FUNC_LOAD_A) a_set[int'(row)*DIM+int'(col)] = 1'b1;
    if (func == FUNC_LOAD_B) b_set[int'(row)*DIM+int'(col)] = 1'b1;
    if (func != FUNC_NONE) item_cnt++;
  endtask

  task automatic run_matrix();
    int unsigned rows;
    int unsigned cols;
    int unsigned b_rows;
    int unsigned i;
    int unsigned j;
    rows   = (cur_rows > DIM) ? DIM : cur_rows;
    cols   = (cur_cols > DIM) ? DIM : cur_cols;
    b_rows = cur_mode[1] ? cols : rows;
    for (i = 0; i < rows; i++) begin
      for (j = 0; j < cols; j++) begin
        if (!a_set[i*DIM+j]) offer(FUNC_LOAD_A, 3'(i), 3'(j), element_value());
      end
    end
    for (i = 0; i < b_rows; i++) begin
      for (j = 0; j < cols; j++) begin
        if (!b_set[i*DIM+j]) offer(FUNC_LOAD_B, 3'(i), 3'(j), element_value());
      end
    end
    offer(FUNC_RUN, 3'($urandom), 3'($urandom), 16'($urandom));
    run_cnt++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] rows, input logic [3:0] cols,
                           input logic [1:0] mode);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_NUM_ROWS;
    cfg_data_i <= rows;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_NUM_COLS;
    cfg_data_i <= cols;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_OP_MODE;
    cfg_data_i <= {2'b00, mode};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_rows = rows;
    cur_cols = cols;
    cur_mode = mode;
    cfg_cnt++;
  endtask

  task automatic random_phase();
    logic [3:0]  rows;
    logic [3:0]  cols;
    logic [1:0]  mode;
    int unsigned pick;
    rows = 4'($urandom_range(1, 4));
    cols = 4'($urandom_range(1, 4));
    mode = 2'($urandom_range(3));
    case ($urandom_range(9))
      0: rows = 4'd0;
      1: cols = 4'd0;
      2: rows = 4'($urandom_range(8, 15));
      3: begin
        rows = 4'd1;
        cols = 4'($urandom_range(8, 15));
        mode = ($urandom_range(1) == 0) ? MODE_ADD : MODE_SUB;
      end
      default: ;
    endcase
    configure(rows, cols, mode);
    repeat ($urandom_range(6, 14)) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        run_matrix();
      end else if (pick < 30) begin
        offer(FUNC_NONE, 3'($urandom), 3'($urandom), 16'($urandom));
      end else begin
        offer(($urandom_range(1) == 0) ? FUNC_LOAD_A : FUNC_LOAD_B,
              3'($urandom), 3'($urandom), element_value());
      end
    end
    run_matrix();
  endtask

  initial begin
    int unsigned directed_items;
    int unsigned phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(4'd2, 4'd2, MODE_ADD);
    offer(FUNC_LOAD_A, 3'd0, 3'd0, 16'sh7fff);
    offer(FUNC_LOAD_A, 3'd0, 3'd1, -16'sh8000);
    offer(FUNC_LOAD_A, 3'd1, 3'd0, -16'sh0001);
    offer(FUNC_LOAD_A, 3'd1, 3'd1, 16'sh0000);
    offer(FUNC_LOAD_B, 3'd0, 3'd0, -16'sh8000);
    offer(FUNC_LOAD_B, 3'd0, 3'd1, 16'sh7fff);
    offer(FUNC_LOAD_B, 3'd1, 3'd0, 16'sh0001);
    offer(FUNC_LOAD_B, 3'd1, 3'd1, -16'sh0001);
    offer(FUNC_LOAD_A, 3'd7, 3'd7, 16'sh5a5a);
    offer(FUNC_LOAD_B, 3'd7, 3'd7, -16'sh2b2b);
    offer(FUNC_NONE, 3'd7, 3'd7, -16'sh0001);
    run_matrix();
    configure(4'd2, 4'd2, MODE_SUB);
    run_matrix();
    configure(4'd2, 4'd2, MODE_MUL);
    run_matrix();
    configure(4'd2, 4'd2, MODE_MUL_ALT);
    run_matrix();
    configure(4'd0, 4'd2, MODE_ADD);
    run_matrix();
    configure(4'd2, 4'd0, MODE_SUB);
    run_matrix();
    configure(4'd15, 4'd1, MODE_MUL);
    run_matrix();
    directed_items = item_cnt;

    configure(4'd3, 4'd3, MODE_MUL);
    hold_req <= 1'b1;
    run_matrix();
    run_matrix();
    repeat (4) offer(FUNC_LOAD_B, 3'($urandom), 3'($urandom), element_value());
    run_matrix();

    phase = 0;
    while (phase < 4 || item_cnt - directed_items < RANDOM_ITEMS) begin
      calm <= (phase == 1);
      random_phase();
      phase++;
    end
    calm <= 1'b0;

    drain();

    $display("Checked %0d result elements from %0d runs over %0d load and run items",
             result_cnt, run_cnt, item_cnt);
    $display("in %0d register settings, with zero and oversized sizes and all modes.",
             cfg_cnt);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
